### sv/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared widths, register indexes and types of the staggered flux curl block.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int MAX_CELLS    = 1024;
  localparam int CELL_W       = $clog2(MAX_CELLS + 1);
  localparam int LB_DEPTH     = MAX_CELLS + 1;
  localparam int SCALE_W      = 32;
  localparam int FRAC_W       = 16;
  localparam int DIFF_W       = SAMPLE_WIDTH + 2;
  localparam int LO_W         = 17;
  localparam int HI_W         = DIFF_W - LO_W;
  localparam int PLO_W        = LO_W + SCALE_W;
  localparam int PHI_W        = HI_W + SCALE_W + 1;
  localparam int PROD_W       = DIFF_W + SCALE_W + 1;
  localparam int SHIFT_W      = PROD_W - FRAC_W;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

  localparam logic [CELL_W-1:0]  CELLS_RESET = CELL_W'(64);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
  localparam logic [CELL_W-1:0]  CELLS_MIN   = CELL_W'(2);
  localparam logic [CELL_W-1:0]  CELLS_MAX   = CELL_W'(MAX_CELLS);

  typedef struct packed {
    logic interior;
    logic last;
  } node_t;

endpackage

### sv/sfc_line_buf.sv
// ----------------------------------------------------------------------------
// sfc_line_buf
// Previous-row y-flux store; registered read, read-first on the same entry.
// ----------------------------------------------------------------------------
module sfc_line_buf (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [sfc_pkg::CELL_W-1:0]          addr_i,
  input  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] wdata_i,
  output logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] rdata_o
);

  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] mem_q [sfc_pkg::LB_DEPTH];
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sfc_scan.sv
// ----------------------------------------------------------------------------
// sfc_scan
// Configuration registers, node scan counters and previous x-flux register.
// ----------------------------------------------------------------------------
module sfc_scan (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                    take_i,
  input  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] x_flux_i,
  output logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] prev_x_o,
  output logic [sfc_pkg::CELL_W-1:0]              slot_o,
  output sfc_pkg::node_t                          node_o,
  output logic [sfc_pkg::SCALE_W-1:0]             scale_o
);

  logic [sfc_pkg::CELL_W-1:0]              nx_q, ny_q, row_q, row_d, col_q, col_d;
  logic [sfc_pkg::CELL_W-1:0]              cells_wr;
  logic [sfc_pkg::SCALE_W-1:0]             scale_q;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] prev_x_q;
  logic                                    end_row, end_grid;

  always_comb begin
    cells_wr = cfg_data_i[sfc_pkg::CELL_W-1:0];
    if (cells_wr < sfc_pkg::CELLS_MIN) begin
      cells_wr = sfc_pkg::CELLS_MIN;
    end else if (cells_wr > sfc_pkg::CELLS_MAX) begin
      cells_wr = sfc_pkg::CELLS_MAX;
    end
  end

  assign end_row  = col_q >= ny_q;
  assign end_grid = end_row && (row_q >= nx_q);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (end_grid) begin
      row_d = '0;
      col_d = '0;
    end else if (end_row) begin
      row_d = row_q + 1'b1;
      col_d = '0;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q     <= sfc_pkg::CELLS_RESET;
      ny_q     <= sfc_pkg::CELLS_RESET;
      scale_q  <= sfc_pkg::SCALE_RESET;
      row_q    <= '0;
      col_q    <= '0;
      prev_x_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == sfc_pkg::CFG_CELLS_X)) begin
        nx_q  <= cells_wr;
        row_q <= '0;
        col_q <= '0;
      end else if (cfg_we_i && (cfg_index_i == sfc_pkg::CFG_CELLS_Y)) begin
        ny_q  <= cells_wr;
        row_q <= '0;
        col_q <= '0;
      end else if (take_i) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (cfg_we_i && (cfg_index_i == sfc_pkg::CFG_SCALE)) begin
        scale_q <= cfg_data_i[sfc_pkg::SCALE_W-1:0];
      end
      if (take_i) begin
        prev_x_q <= x_flux_i;
      end
    end
  end

  assign prev_x_o        = prev_x_q;
  assign slot_o          = col_q;
  assign scale_o         = scale_q;
  assign node_o.interior = (row_q != '0) && (row_q < nx_q) && (col_q != '0) && (col_q < ny_q);
  assign node_o.last     = end_grid;

endmodule

### sv/sfc_mul_sat.sv
// ----------------------------------------------------------------------------
// sfc_mul_sat
// Two-stage scale: split partial products, then sum, floor shift, saturate.
// ----------------------------------------------------------------------------
module sfc_mul_sat (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [sfc_pkg::DIFF_W-1:0]       diff_i,
  input  logic [sfc_pkg::SCALE_W-1:0]             scale_i,
  input  sfc_pkg::node_t                          node_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] curl_o,
  output logic                                    last_o
);

  localparam logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] SatMax =
    {1'b0, {(sfc_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] SatMin =
    {1'b1, {(sfc_pkg::SAMPLE_WIDTH-1){1'b0}}};

  logic                                    p_v_q, p_ready, o_v_q, o_ready;
  logic [sfc_pkg::PLO_W-1:0]               plo_q;
  logic signed [sfc_pkg::PHI_W-1:0]        phi_q;
  sfc_pkg::node_t                          pnode_q;
  logic signed [sfc_pkg::PROD_W-1:0]       prod;
  logic signed [sfc_pkg::SHIFT_W-1:0]      shifted;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] sat, curl_q;
  logic                                    last_q;
  logic                                    fits;

  assign o_ready    = !o_v_q || out_ready_i;
  assign p_ready    = !p_v_q || o_ready;
  assign in_ready_o = p_ready;

  assign prod = (sfc_pkg::PROD_W'(phi_q) <<< sfc_pkg::LO_W)
              + $signed({{(sfc_pkg::PROD_W-sfc_pkg::PLO_W){1'b0}}, plo_q});
  assign shifted = prod[sfc_pkg::PROD_W-1:sfc_pkg::FRAC_W];
  assign fits = (shifted[sfc_pkg::SHIFT_W-1:sfc_pkg::SAMPLE_WIDTH-1] == '0)
             || (shifted[sfc_pkg::SHIFT_W-1:sfc_pkg::SAMPLE_WIDTH-1] == '1);

  always_comb begin
    if (fits) begin
      sat = shifted[sfc_pkg::SAMPLE_WIDTH-1:0];
    end else if (shifted[sfc_pkg::SHIFT_W-1]) begin
      sat = SatMin;
    end else begin
      sat = SatMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (p_ready) begin
        p_v_q <= in_valid_i;
      end
      if (o_ready) begin
        o_v_q <= p_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && in_valid_i) begin
      plo_q   <= diff_i[sfc_pkg::LO_W-1:0] * scale_i;
      phi_q   <= $signed(diff_i[sfc_pkg::DIFF_W-1:sfc_pkg::LO_W]) * $signed({1'b0, scale_i});
      pnode_q <= node_i;
    end
    if (o_ready && p_v_q) begin
      curl_q <= pnode_q.interior ? sat : '0;
      last_q <= pnode_q.last;
    end
  end

  assign out_valid_o = o_v_q;
  assign curl_o      = curl_q;
  assign last_o      = last_q;

endmodule

### sv/staggered_flux_curl_stencil.sv
// ----------------------------------------------------------------------------
// staggered_flux_curl_stencil
// Discrete curl of a staggered flux field over a streamed node grid.
// ----------------------------------------------------------------------------
// Usage:
//   Stream nodes in row order on s_axis: tdata = {y_flux, x_flux}, one node
//   per beat, rows i = 0..nx, columns j = 0..ny. Each node gives one beat on
//   m_axis: tdata = curl_value, tlast marks node (nx,ny). Boundary nodes give
//   zero. The scan wraps to node (0,0) after the last node.
//   Configure through cfg (index 0 nx, 1 ny, 2 Q16.16 scale) only while the
//   block is idle; writing nx or ny restarts the scan at node (0,0).
//   Throughput is one node per cycle unless m_axis stalls: the line buffer is
//   read and written once per node on a single port, and the scale multiply is
//   split over two registered stages, which follow the s1 and s2 registers.
//   When m_axis stalls, the four stages fill in turn and s_axis_tready drops
//   only once every stage holds a beat. Reset sets nx = ny = 64, scale = 1.0,
//   empties the pipeline and starts the scan at node (0,0); the line buffer
//   holds no reset value, and row 0 never uses what it reads.
// ----------------------------------------------------------------------------
module staggered_flux_curl_stencil (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*sfc_pkg::SAMPLE_WIDTH-1:0]  s_axis_tdata,  // y_flux, x_flux
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sfc_pkg::SAMPLE_WIDTH-1:0]    m_axis_tdata,  // curl_value
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic                                    take, cfg_we;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] x_flux, y_flux, prev_x, qy_above, curl;
  logic [sfc_pkg::CELL_W-1:0]              slot;
  logic [sfc_pkg::SCALE_W-1:0]             scale;
  sfc_pkg::node_t                          node;

  logic                                    s1_v_q, s1_ready, s2_v_q, s2_ready, mul_ready;
  logic signed [sfc_pkg::DIFF_W-1:0]       s1_part_q, s2_diff_q;
  sfc_pkg::node_t                          s1_node_q, s2_node_q;

  assign x_flux = s_axis_tdata[sfc_pkg::SAMPLE_WIDTH-1:0];
  assign y_flux = s_axis_tdata[2*sfc_pkg::SAMPLE_WIDTH-1:sfc_pkg::SAMPLE_WIDTH];

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign s2_ready      = !s2_v_q || mul_ready;
  assign s1_ready      = !s1_v_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign take          = s_axis_tvalid && s_axis_tready;

  sfc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .x_flux_i    (x_flux),
    .prev_x_o    (prev_x),
    .slot_o      (slot),
    .node_o      (node),
    .scale_o     (scale)
  );

  sfc_line_buf u_line_buf (
    .clk_i   (clk_i),
    .en_i    (take),
    .addr_i  (slot),
    .wdata_i (y_flux),
    .rdata_o (qy_above)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= take;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_part_q <= sfc_pkg::DIFF_W'(y_flux) + sfc_pkg::DIFF_W'(prev_x)
                 - sfc_pkg::DIFF_W'(x_flux);
      s1_node_q <= node;
    end
    if (s2_ready && s1_v_q) begin
      s2_diff_q <= s1_part_q - sfc_pkg::DIFF_W'(qy_above);
      s2_node_q <= s1_node_q;
    end
  end

  sfc_mul_sat u_mul_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_v_q),
    .in_ready_o  (mul_ready),
    .diff_i      (s2_diff_q),
    .scale_i     (scale),
    .node_i      (s2_node_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .curl_o      (curl),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = curl;

  a_last_is_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
    else $error("last node beat carries a nonzero curl");

  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> s1_v_q)
    else $error("accepted beat lost before the difference stage");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !mul_ready |=> s2_v_q && $stable(s2_diff_q) && $stable(s2_node_q))
    else $error("difference stage changed while stalled");

endmodule

### tb/tb_staggered_flux_curl_stencil.sv
// ----------------------------------------------------------------------------
// tb_staggered_flux_curl_stencil
// Self-checking bench for the staggered flux curl stencil. Node beats are
// streamed in row order over a range of grid sizes and scales, and every curl
// beat is checked against a cycle-free predictor of the scan, the line buffer
// and the floor/saturate scaling. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_staggered_flux_curl_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDE_W          = 64 + sfc_pkg::SCALE_W + 1;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CALM_TAIL       = 200;
  localparam int BURST_MAX       = 7;
  localparam int RANDOM_NODES    = 300;
  localparam int LONG_ROW_NODES  = sfc_pkg::MAX_CELLS + 9;
  localparam int SHORT_ROW_NODES = 60;

  localparam logic [sfc_pkg::CFG_IDX_W-1:0]    CFG_UNUSED = 2'd3;
  localparam logic [sfc_pkg::SAMPLE_WIDTH-1:0] FLUX_MIN   =
    {1'b1, {(sfc_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [sfc_pkg::SAMPLE_WIDTH-1:0] FLUX_MAX   = ~FLUX_MIN;
  localparam logic [sfc_pkg::SAMPLE_WIDTH-1:0] FLUX_ONE   = sfc_pkg::SAMPLE_WIDTH'(1);
  localparam logic [sfc_pkg::SAMPLE_WIDTH-1:0] FLUX_NEG1  = '1;
  localparam logic [sfc_pkg::SAMPLE_WIDTH-1:0] FLUX_ZERO  = '0;

  typedef enum logic {OP_NODE, OP_WRITE} op_kind_e;

  typedef struct {
    op_kind_e                         kind;
    logic [sfc_pkg::CFG_IDX_W-1:0]    index;
    logic [sfc_pkg::CFG_DATA_W-1:0]   data;
    logic [sfc_pkg::SAMPLE_WIDTH-1:0] qx;
    logic [sfc_pkg::SAMPLE_WIDTH-1:0] qy;
  } stim_op_t;

  typedef struct {
    logic [sfc_pkg::SAMPLE_WIDTH-1:0] curl;
    logic                             last;
  } curl_beat_t;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [2*sfc_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata  = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [sfc_pkg::SAMPLE_WIDTH-1:0]   m_axis_tdata;
  logic                               m_axis_tlast;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [sfc_pkg::CFG_IDX_W-1:0]      cfg_index_i   = '0;
  logic [sfc_pkg::CFG_DATA_W-1:0]     cfg_data_i    = '0;

  stim_op_t   op_q[$];
  curl_beat_t curl_q[$];

  // predictor state
  logic [sfc_pkg::CELL_W-1:0]              cells_x;
  logic [sfc_pkg::CELL_W-1:0]              cells_y;
  logic [sfc_pkg::SCALE_W-1:0]             inv_dx2;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] row_above_y [sfc_pkg::MAX_CELLS+1];
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] left_x;
  int                                      scan_row;
  int                                      scan_col;

  int gen_nx, gen_ny;
  int src_gap, sink_gap, quiet_cycles;
  bit src_idle_on, sink_idle_on;
  int nodes_in, writes_in, results_out, grids_out, interior_nodes, mismatches;

  staggered_flux_curl_stencil u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int clamp_cells(logic [sfc_pkg::CELL_W-1:0] v);
    if (v < sfc_pkg::CELLS_MIN) return int'(sfc_pkg::CELLS_MIN);
    if (v > sfc_pkg::CELLS_MAX) return int'(sfc_pkg::CELLS_MAX);
    return int'(v);
  endfunction

  function automatic logic [sfc_pkg::SAMPLE_WIDTH-1:0] scale_curl(
      longint diff, logic [sfc_pkg::SCALE_W-1:0] s);
    logic signed [WIDE_W-1:0] prod;
    prod = diff * $signed({1'b0, s});
    prod = prod >>> sfc_pkg::FRAC_W;
    if (prod[WIDE_W-1:sfc_pkg::SAMPLE_WIDTH-1] == '0 ||
        prod[WIDE_W-1:sfc_pkg::SAMPLE_WIDTH-1] == '1)
      return prod[sfc_pkg::SAMPLE_WIDTH-1:0];
    return prod[WIDE_W-1] ? FLUX_MIN : FLUX_MAX;
  endfunction

  function automatic void apply_write(logic [sfc_pkg::CFG_IDX_W-1:0] idx,
                                      logic [sfc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sfc_pkg::CFG_CELLS_X: begin
        cells_x  = data[sfc_pkg::CELL_W-1:0];
        scan_row = 0;
        scan_col = 0;
      end
      sfc_pkg::CFG_CELLS_Y: begin
        cells_y  = data[sfc_pkg::CELL_W-1:0];
        scan_row = 0;
        scan_col = 0;
      end
      sfc_pkg::CFG_SCALE: inv_dx2 = data[sfc_pkg::SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic curl_beat_t predict_node(logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] qx,
                                              logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] qy);
    curl_beat_t beat;
    int         nx, ny;
    longint     diff;
    nx = clamp_cells(cells_x);
    ny = clamp_cells(cells_y);
    beat.curl = '0;
    beat.last = (scan_col >= ny) && (scan_row >= nx);
    if (scan_row > 0 && scan_row < nx && scan_col > 0 && scan_col < ny) begin
      diff = longint'(qy) - longint'(row_above_y[scan_col]) - longint'(qx) + longint'(left_x);
      beat.curl = scale_curl(diff, inv_dx2);
      interior_nodes++;
    end
    row_above_y[scan_col] = qy;
    left_x = qx;
    if (beat.last) begin
      scan_row = 0;
      scan_col = 0;
    end else if (scan_col >= ny) begin
      scan_row++;
      scan_col = 0;
    end else begin
      scan_col++;
    end
    return beat;
  endfunction

  function automatic logic [sfc_pkg::SAMPLE_WIDTH-1:0] rand_flux();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 7))
      0: return FLUX_MIN;
      1: return FLUX_MAX;
      2, 3: return raw;
      default: return {{12{raw[19]}}, raw[19:0]};
    endcase
  endfunction

  function automatic logic [sfc_pkg::SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return sfc_pkg::SCALE_RESET;
      3: return $urandom();
      default: return $urandom_range(1, 1 << 18);
    endcase
  endfunction

  function automatic logic [sfc_pkg::CFG_DATA_W-1:0] rand_cells();
    logic [sfc_pkg::CFG_DATA_W-1:0] raw;
    raw = $urandom();
    raw[sfc_pkg::CELL_W-1:0] = sfc_pkg::CELL_W'($urandom_range(0, 9));
    return $urandom_range(0, 1) ? raw :
      {{(sfc_pkg::CFG_DATA_W-sfc_pkg::CELL_W){1'b0}}, raw[sfc_pkg::CELL_W-1:0]};
  endfunction

  function automatic void queue_write(logic [sfc_pkg::CFG_IDX_W-1:0] idx,
                                      logic [sfc_pkg::CFG_DATA_W-1:0] data);
    stim_op_t op;
    op.kind  = OP_WRITE;
    op.index = idx;
    op.data  = data;
    op.qx    = '0;
    op.qy    = '0;
    op_q.push_back(op);
    if (idx == sfc_pkg::CFG_CELLS_X) gen_nx = clamp_cells(data[sfc_pkg::CELL_W-1:0]);
    if (idx == sfc_pkg::CFG_CELLS_Y) gen_ny = clamp_cells(data[sfc_pkg::CELL_W-1:0]);
  endfunction

  function automatic void queue_node(logic [sfc_pkg::SAMPLE_WIDTH-1:0] qx,
                                     logic [sfc_pkg::SAMPLE_WIDTH-1:0] qy);
    stim_op_t op;
    op.kind  = OP_NODE;
    op.index = '0;
    op.data  = '0;
    op.qx    = qx;
    op.qy    = qy;
    op_q.push_back(op);
  endfunction

  function automatic void queue_random_nodes(int count);
    for (int k = 0; k < count; k++) queue_node(rand_flux(), rand_flux());
  endfunction

  // sender: node beats and register writes; writes only once the pipe is empty
  always @(posedge clk_i or negedge rst_ni) begin
    stim_op_t op;
    logic     send_node;
    logic     send_write;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        curl_q.push_back(predict_node(
          s_axis_tdata[sfc_pkg::SAMPLE_WIDTH-1:0],
          s_axis_tdata[2*sfc_pkg::SAMPLE_WIDTH-1:sfc_pkg::SAMPLE_WIDTH]));
        nodes_in++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_write(cfg_index_i, cfg_data_i);
        writes_in++;
      end
      if (curl_q.size() == 0 && !s_axis_tvalid) quiet_cycles++;
      else quiet_cycles = 0;
      if ($urandom_range(0, 63) == 0) src_idle_on = !src_idle_on;
      if (!(s_axis_tvalid && !s_axis_tready) && !(cfg_valid_i && !cfg_ready_o)) begin
        send_node  = 1'b0;
        send_write = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (op_q.size() > 0) begin
          if (op_q[0].kind == OP_NODE) begin
            op = op_q.pop_front();
            send_node = 1'b1;
            s_axis_tdata <= {op.qy, op.qx};
            if (src_idle_on && op_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
              src_gap = $urandom_range(1, BURST_MAX);
          end else if (curl_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
            op = op_q.pop_front();
            send_write = 1'b1;
            cfg_index_i <= op.index;
            cfg_data_i  <= op.data;
          end
        end
        s_axis_tvalid <= send_node;
        cfg_valid_i   <= send_write;
      end
    end
  end

  // receiver: random backpressure bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) sink_idle_on = !sink_idle_on;
      if (sink_gap == 0 && sink_idle_on && op_q.size() >= CALM_TAIL &&
          $urandom_range(0, 7) == 0)
        sink_gap = $urandom_range(1, BURST_MAX);
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    curl_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_out++;
      if (m_axis_tlast) grids_out++;
      if (curl_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR beat %0d: unexpected curl %h last %b", results_out,
                   m_axis_tdata, m_axis_tlast);
      end else begin
        want = curl_q.pop_front();
        if (m_axis_tdata !== want.curl || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR beat %0d: curl exp %h got %h, last exp %b got %b",
                     results_out, want.curl, m_axis_tdata, want.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    int random_nodes;
    int grid_nodes;
    cells_x      = sfc_pkg::CELLS_RESET;
    cells_y      = sfc_pkg::CELLS_RESET;
    inv_dx2      = sfc_pkg::SCALE_RESET;
    left_x       = '0;
    scan_row     = 0;
    scan_col     = 0;
    gen_nx       = int'(sfc_pkg::CELLS_RESET);
    gen_ny       = int'(sfc_pkg::CELLS_RESET);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;

    // reset settings, then an ignored write that must not restart the scan
    queue_random_nodes(60);
    queue_write(CFG_UNUSED, $urandom());
    queue_random_nodes(20);

    // smallest grid from below-minimum sizes; drive both saturation limits
    queue_write(sfc_pkg::CFG_CELLS_X, 0);
    queue_write(sfc_pkg::CFG_CELLS_Y, 1);
    queue_write(sfc_pkg::CFG_SCALE, sfc_pkg::SCALE_RESET);
    queue_node(FLUX_ZERO, FLUX_ZERO);
    queue_node(FLUX_ZERO, FLUX_MIN);
    queue_node(FLUX_MIN,  FLUX_MAX);
    queue_node(FLUX_MAX,  FLUX_MAX);
    queue_node(FLUX_MIN,  FLUX_MAX);
    queue_node(FLUX_MAX,  FLUX_MIN);
    queue_node(FLUX_MIN,  FLUX_MIN);
    queue_node(FLUX_MAX,  FLUX_MAX);
    queue_node(FLUX_NEG1, FLUX_NEG1);
    queue_node(FLUX_NEG1, FLUX_ZERO);
    queue_node(FLUX_ZERO, FLUX_MAX);
    queue_node(FLUX_ONE,  FLUX_ONE);
    queue_node(FLUX_MIN,  FLUX_NEG1);
    queue_node(FLUX_MAX,  FLUX_MIN);
    queue_node(FLUX_ZERO, FLUX_ZERO);
    queue_node(FLUX_ONE,  FLUX_NEG1);
    queue_node(FLUX_NEG1, FLUX_ONE);
    queue_node(FLUX_MAX,  FLUX_MIN);

    // largest sizes along each axis: many short rows, then one long row and on
    queue_write(sfc_pkg::CFG_CELLS_X, sfc_pkg::MAX_CELLS);
    queue_write(sfc_pkg::CFG_CELLS_Y, 2);
    queue_write(sfc_pkg::CFG_SCALE, rand_scale());
    queue_random_nodes(SHORT_ROW_NODES);
    queue_write(sfc_pkg::CFG_CELLS_X, 2);
    queue_write(sfc_pkg::CFG_CELLS_Y,
                {{(sfc_pkg::CFG_DATA_W-sfc_pkg::CELL_W){1'b0}}, {sfc_pkg::CELL_W{1'b1}}});
    queue_write(sfc_pkg::CFG_SCALE, {1'b1, {(sfc_pkg::SCALE_W-1){1'b0}}});
    queue_random_nodes(LONG_ROW_NODES);

    queue_write(sfc_pkg::CFG_CELLS_X, rand_cells());
    queue_write(sfc_pkg::CFG_CELLS_Y, rand_cells());
    random_nodes = 0;
    while (random_nodes < RANDOM_NODES) begin
      if ($urandom_range(0, 1)) queue_write(sfc_pkg::CFG_CELLS_X, rand_cells());
      if ($urandom_range(0, 1)) queue_write(sfc_pkg::CFG_CELLS_Y, rand_cells());
      if ($urandom_range(0, 2) == 0) queue_write(sfc_pkg::CFG_SCALE, rand_scale());
      if ($urandom_range(0, 9) == 0) queue_write(CFG_UNUSED, $urandom());
      grid_nodes = (gen_nx + 1) * (gen_ny + 1);
      grid_nodes = $urandom_range(0, 1) ? $urandom_range(1, 3) * grid_nodes
                                        : $urandom_range(1, 2 * grid_nodes);
      queue_random_nodes(grid_nodes);
      random_nodes += grid_nodes;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || s_axis_tvalid || cfg_valid_i || curl_q.size() != 0)
      @(negedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (curl_q.size() != 0) begin
      mismatches++;
      $display("ERROR %0d curl beats never arrived", curl_q.size());
    end

    $display("Streamed %0d nodes (%0d interior) with %0d register writes.",
             nodes_in, interior_nodes, writes_in);
    $display("Checked %0d curl beats closing %0d grids, %0d mismatches.",
             results_out, grids_out, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
